// ===== sv/rsmf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the ratio and symmetry match filter.
// No dependencies; every other file of the block but rsmf_ram uses it.
package rsmf_pkg;

    localparam int CMD_W   = 2;
    localparam int INDEX_W = 16;
    localparam int DIST_W  = 24;
    localparam int RATIO_W = 17;
    localparam int COUNT_W = 16;
    localparam int ENTRY_W = 2 * INDEX_W;
    localparam int PROD_W  = RATIO_W + DIST_W;

    localparam logic [RATIO_W-1:0] RATIO_RESET = 17'd62259;

    // Command codes of an input beat
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TEST  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULT,
        ST_EVAL,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [INDEX_W-1:0] query_index;
        logic [INDEX_W-1:0] train_index;
        logic [DIST_W-1:0]  best_distance;
        logic [DIST_W-1:0]  second_distance;
        logic               has_second;
    } item_t;

    typedef struct packed {
        logic               passed_ratio;
        logic               symmetric;
        logic [INDEX_W-1:0] match_query;
        logic [INDEX_W-1:0] match_train;
        logic [DIST_W-1:0]  match_distance;
        logic [COUNT_W-1:0] rejected_count;
        logic               table_full;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic latch;
        logic mult;
        logic eval;
        logic scan_step;
        logic emit;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_scan;
        logic scan_done;
        logic out_busy;
    } dp_status_t;

endpackage

// ===== sv/rsmf_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the match filter: valid/ready handshake and one match item.
// Depends on rsmf_pkg for field widths.
interface rsmf_in_if;
    logic                          valid;
    logic                          ready;
    logic [rsmf_pkg::CMD_W-1:0]    command;
    logic [rsmf_pkg::INDEX_W-1:0]  query_index;
    logic [rsmf_pkg::INDEX_W-1:0]  train_index;
    logic [rsmf_pkg::DIST_W-1:0]   best_distance;
    logic [rsmf_pkg::DIST_W-1:0]   second_distance;
    logic                          has_second;

    modport source (
        output valid, command, query_index, train_index,
               best_distance, second_distance, has_second,
        input  ready
    );

    modport sink (
        input  valid, command, query_index, train_index,
               best_distance, second_distance, has_second,
        output ready
    );
endinterface

// ===== sv/rsmf_out_if.sv =====
`timescale 1ns / 1ps
// Output channel of the match filter: valid/ready handshake and one result.
// Depends on rsmf_pkg for field widths.
interface rsmf_out_if;
    logic                          valid;
    logic                          ready;
    logic                          passed_ratio;
    logic                          symmetric;
    logic [rsmf_pkg::INDEX_W-1:0]  match_query;
    logic [rsmf_pkg::INDEX_W-1:0]  match_train;
    logic [rsmf_pkg::DIST_W-1:0]   match_distance;
    logic [rsmf_pkg::COUNT_W-1:0]  rejected_count;
    logic                          table_full;

    modport source (
        output valid, passed_ratio, symmetric, match_query, match_train,
               match_distance, rejected_count, table_full,
        input  ready
    );

    modport sink (
        input  valid, passed_ratio, symmetric, match_query, match_train,
               match_distance, rejected_count, table_full,
        output ready
    );
endinterface

// ===== sv/rsmf_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rsmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/rsmf_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the match filter: accept, multiply, evaluate, scan, emit.
// Depends on rsmf_pkg for the state, command and status types.
module rsmf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rsmf_pkg::dp_status_t status,
    output rsmf_pkg::dp_cmd_t    cmd
);

    rsmf_pkg::state_t state_reg;
    rsmf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rsmf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rsmf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rsmf_pkg::ST_MULT;
                end
            end
            rsmf_pkg::ST_MULT:
            begin
                state_next = rsmf_pkg::ST_EVAL;
            end
            rsmf_pkg::ST_EVAL:
            begin
                state_next = status.need_scan ? rsmf_pkg::ST_SCAN : rsmf_pkg::ST_EMIT;
            end
            rsmf_pkg::ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = rsmf_pkg::ST_EMIT;
                end
            end
            rsmf_pkg::ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    state_next = rsmf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rsmf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            rsmf_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
            end
            rsmf_pkg::ST_MULT:
            begin
                cmd.mult = 1'b1;
            end
            rsmf_pkg::ST_EVAL:
            begin
                cmd.eval = 1'b1;
            end
            rsmf_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            rsmf_pkg::ST_EMIT:
            begin
                cmd.emit = !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== sv/rsmf_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the match filter: item registers, ratio multiplier, counters,
// reverse table with its scan pointer, and the output register.
// Depends on rsmf_pkg and rsmf_ram.
module rsmf_datapath #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [rsmf_pkg::RATIO_W-1:0]        cfg_write_data,
    input  rsmf_pkg::item_t                     item,
    input  rsmf_pkg::dp_cmd_t                   cmd,
    output rsmf_pkg::dp_status_t                status,
    output logic                                out_valid,
    input  logic                                out_ready,
    output rsmf_pkg::result_t                   result
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(TABLE_DEPTH);

    function automatic logic [rsmf_pkg::COUNT_W-1:0] sat_inc(
        input logic [rsmf_pkg::COUNT_W-1:0] c
    );
        return (&c) ? c : c + rsmf_pkg::COUNT_W'(1);
    endfunction

    logic [rsmf_pkg::RATIO_W-1:0] ratio_reg;
    rsmf_pkg::item_t              item_reg;
    logic [rsmf_pkg::PROD_W-1:0]  product_reg;
    logic                         pass_reg;
    logic                         sym_reg;
    logic                         full_reg;
    logic [FILL_W-1:0]            fill_reg;
    logic [rsmf_pkg::COUNT_W-1:0] rev_rej_reg;
    logic [rsmf_pkg::COUNT_W-1:0] fwd_rej_reg;
    logic [FILL_W-1:0]            scan_idx_reg;
    logic [FILL_W-1:0]            scan_idx_inc;
    logic                         rd_valid_reg;
    logic                         last_reg;
    logic                         out_valid_reg;
    rsmf_pkg::result_t            result_reg;
    rsmf_pkg::result_t            result_next;

    logic                          pass_now;
    logic                          is_load;
    logic                          is_test;
    logic                          is_clear;
    logic                          ram_we;
    logic [rsmf_pkg::ENTRY_W-1:0]  ram_rdata;
    logic                          entry_hit;

    assign is_load  = item_reg.command == rsmf_pkg::CMD_LOAD;
    assign is_test  = item_reg.command == rsmf_pkg::CMD_TEST;
    assign is_clear = item_reg.command == rsmf_pkg::CMD_CLEAR;

    // best * 65536 <= ratio * second, exact
    assign pass_now = item_reg.has_second &&
        ({1'b0, item_reg.best_distance, 16'h0000} <= product_reg);

    assign ram_we = cmd.eval && is_load && pass_now && (fill_reg < FILL_MAX);

    // Stored entry holds {query, train} of a reverse match
    assign entry_hit = (ram_rdata[rsmf_pkg::INDEX_W-1:0] == item_reg.query_index) &&
        (ram_rdata[rsmf_pkg::ENTRY_W-1:rsmf_pkg::INDEX_W] == item_reg.train_index);

    assign scan_idx_inc = scan_idx_reg + FILL_W'(1);

    rsmf_ram #(
        .WIDTH (rsmf_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata ({item_reg.query_index, item_reg.train_index}),
        .raddr (scan_idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign status.need_scan = is_test && pass_now && (fill_reg != '0);
    assign status.scan_done = rd_valid_reg && (entry_hit || last_reg);
    assign status.out_busy  = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg <= rsmf_pkg::RATIO_RESET;
        end
        else if (cfg_write_en)
        begin
            ratio_reg <= cfg_write_data;
        end
    end

    // Item and product registers: payload only
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            item_reg <= item;
        end
        if (cmd.mult)
        begin
            product_reg <= rsmf_pkg::PROD_W'(ratio_reg) *
                           rsmf_pkg::PROD_W'(item_reg.second_distance);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_reg     <= 1'b0;
            sym_reg      <= 1'b0;
            full_reg     <= 1'b0;
            fill_reg     <= '0;
            rev_rej_reg  <= '0;
            fwd_rej_reg  <= '0;
            scan_idx_reg <= '0;
            rd_valid_reg <= 1'b0;
            last_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.latch)
            begin
                pass_reg     <= 1'b0;
                sym_reg      <= 1'b0;
                full_reg     <= 1'b0;
                scan_idx_reg <= '0;
                rd_valid_reg <= 1'b0;
                last_reg     <= 1'b0;
            end
            if (cmd.eval)
            begin
                pass_reg <= (is_load || is_test) && pass_now;
                if (is_load)
                begin
                    if (!pass_now)
                    begin
                        rev_rej_reg <= sat_inc(rev_rej_reg);
                    end
                    else if (fill_reg < FILL_MAX)
                    begin
                        fill_reg <= fill_reg + FILL_W'(1);
                    end
                    else
                    begin
                        full_reg <= 1'b1;
                    end
                end
                if (is_test && !pass_now)
                begin
                    fwd_rej_reg <= sat_inc(fwd_rej_reg);
                end
                if (is_clear)
                begin
                    fill_reg    <= '0;
                    rev_rej_reg <= '0;
                    fwd_rej_reg <= '0;
                end
                // Address zero is read this cycle; advance to the next
                if (status.need_scan)
                begin
                    scan_idx_reg <= FILL_W'(1);
                    rd_valid_reg <= 1'b1;
                    last_reg     <= fill_reg == FILL_W'(1);
                end
            end
            if (cmd.scan_step && rd_valid_reg)
            begin
                if (entry_hit)
                begin
                    sym_reg <= 1'b1;
                end
                if (entry_hit || last_reg)
                begin
                    rd_valid_reg <= 1'b0;
                end
                else
                begin
                    scan_idx_reg <= scan_idx_inc;
                    last_reg     <= scan_idx_inc == fill_reg;
                end
            end
        end
    end

    always_comb
    begin
        result_next                = '0;
        result_next.passed_ratio   = pass_reg;
        result_next.symmetric      = sym_reg;
        result_next.table_full     = full_reg;
        if (sym_reg)
        begin
            result_next.match_query = item_reg.query_index;
            result_next.match_train = item_reg.train_index;
        end
        if (is_test)
        begin
            result_next.match_distance = item_reg.best_distance;
            result_next.rejected_count = fwd_rej_reg;
        end
        else if (is_load)
        begin
            result_next.rejected_count = rev_rej_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// ===== sv/ratio_and_symmetry_match_filter_core.sv =====
`timescale 1ns / 1ps
// Top level of the ratio and symmetry match filter.
// Depends on rsmf_pkg, rsmf_in_if, rsmf_out_if, rsmf_ctrl, rsmf_datapath, rsmf_ram.

// Feature-match filter applying a distance ratio test with a cross check.
// Each input beat carries one match and a command: load stores a reverse
// match that passes the ratio test (best * 65536 <= ratio_q16 * second, and
// a second neighbor must exist) into a table of TABLE_DEPTH entries; test
// ratio-checks a forward match and then scans the table for the mutual
// reverse pair; clear empties the table and both reject counters. Every
// input beat yields exactly one result beat. Steps: an item is taken in
// the idle state, then the ratio product is registered, the test is
// evaluated, and the result is loaded into the output register. Load,
// clear, no-op and tests that fail or find the table empty skip the
// table scan between the evaluation and the output register.
// A passing test reads the table through the single read port of its RAM,
// one entry per cycle, and stops at the first mutual entry or after the
// last stored entry. The output register lets the next item be accepted
// while the previous result still waits; a result that is still held when
// the next one is ready stalls the block.
// The ratio register may be written only while the block is idle.
module ratio_and_symmetry_match_filter_core #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [rsmf_pkg::RATIO_W-1:0]  cfg_write_data,
    rsmf_in_if.sink                       items,
    rsmf_out_if.source                    results
);

    rsmf_pkg::dp_cmd_t    dp_cmd;
    rsmf_pkg::dp_status_t dp_status;
    rsmf_pkg::item_t      item;
    rsmf_pkg::result_t    result;
    logic                 in_ready;
    logic                 out_valid;

    // Gather the input payload into one word for the datapath
    assign item.command         = items.command;
    assign item.query_index     = items.query_index;
    assign item.train_index     = items.train_index;
    assign item.best_distance   = items.best_distance;
    assign item.second_distance = items.second_distance;
    assign item.has_second      = items.has_second;
    assign items.ready          = in_ready;

    rsmf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_ready (in_ready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    rsmf_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .item           (item),
        .cmd            (dp_cmd),
        .status         (dp_status),
        .out_valid      (out_valid),
        .out_ready      (results.ready),
        .result         (result)
    );

    // Drive the result beat from the output register
    assign results.valid          = out_valid;
    assign results.passed_ratio   = result.passed_ratio;
    assign results.symmetric      = result.symmetric;
    assign results.match_query    = result.match_query;
    assign results.match_train    = result.match_train;
    assign results.match_distance = result.match_distance;
    assign results.rejected_count = result.rejected_count;
    assign results.table_full     = result.table_full;

endmodule
